// File: sv/lpw_pkg.sv
// Shared types and constants for the line pixel writer.
package lpw_pkg;

    localparam int FRAME_WIDTH  = 1024;
    localparam int FRAME_HEIGHT = 1024;
    localparam int FRAME_MAX    = (FRAME_WIDTH > FRAME_HEIGHT) ? FRAME_WIDTH : FRAME_HEIGHT;
    // clipped coordinates are below FRAME_MAX
    localparam int CLIP_W       = (FRAME_MAX > 1) ? $clog2(FRAME_MAX) : 1;

    localparam int COORD_W    = 16;
    localparam int ERR_W      = 17;
    localparam int COLOR_W    = 24;
    localparam int ADDR_W     = 24;
    localparam int STRIDE_W   = 15;
    localparam int BPP_W      = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STRIDE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BPP        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_ENDIAN = 3'd4;

    localparam logic [STRIDE_W-1:0] STRIDE_RESET = 15'd4096;
    localparam logic [BPP_W-1:0]    BPP_RESET    = 3'd4;

    typedef struct packed {
        logic [COORD_W-1:0]  offset_x;
        logic [COORD_W-1:0]  offset_y;
        logic [STRIDE_W-1:0] stride;
        logic [BPP_W-1:0]    bpp;
        logic                big_endian;
    } t_cfg;

    // classified command as it sits in the queue
    typedef struct packed {
        logic                is_start;
        logic [COORD_W-1:0]  start_x;
        logic [COORD_W-1:0]  start_y;
        logic [COORD_W-1:0]  span_x;
        logic [COORD_W-1:0]  span_y;
        logic                dir_x;
        logic                dir_y;
        logic [COLOR_W-1:0]  color;
    } t_op;

    // one generated pixel before offset, clip and address
    typedef struct packed {
        logic                idle;
        logic                last;
        logic [COORD_W-1:0]  x;
        logic [COORD_W-1:0]  y;
        logic [COLOR_W-1:0]  color;
    } t_pix;

endpackage

// File: sv/line_pixel_writer.sv
// Top level of the Bresenham line pixel writer.
// A start transaction (cmd 0) loads two endpoints and a color and produces no
// result; each step transaction (cmd 1) produces exactly one result: a clipped
// pixel write of the next point on the line, or an idle result when no line is
// in progress. Steady state is one transaction per clock on both channels,
// starts included, while the result side does not stall; the figure is set by
// the generator's combinational error update. Accepted commands pass a 4-entry
// queue into the generator, then a three-stage back end (offset and clip,
// address products, output register), each stage holding while the next is full.
// Configuration is taken with o_cfg_ready always high and must be written
// only while no line transactions are outstanding.
module line_pixel_writer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lpw_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [lpw_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_cmd,
    input  logic signed [15:0]                 i_start_x,
    input  logic signed [15:0]                 i_start_y,
    input  logic signed [15:0]                 i_end_x,
    input  logic signed [15:0]                 i_end_y,
    input  logic [23:0]                        i_color,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic                               o_write_enable,
    output logic [23:0]                        o_byte_address,
    output logic [23:0]                        o_pixel_bytes,
    output logic                               o_last_pixel,
    output logic                               o_idle
);
    import lpw_pkg::*;

    t_cfg   r_cfg;
    logic   fifo_full;
    logic   push;
    t_op    front_op;
    logic   q_valid;
    t_op    q_op;
    logic   q_ready;
    logic   pix_valid;
    t_pix   pix;
    logic   pix_ready;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_x   <= '0;
            r_cfg.offset_y   <= '0;
            r_cfg.stride     <= STRIDE_RESET;
            r_cfg.bpp        <= BPP_RESET;
            r_cfg.big_endian <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_OFFSET_X:   r_cfg.offset_x   <= i_cfg_data;
                CFG_OFFSET_Y:   r_cfg.offset_y   <= i_cfg_data;
                CFG_STRIDE:     r_cfg.stride     <= i_cfg_data[STRIDE_W-1:0];
                CFG_BPP:        r_cfg.bpp        <= i_cfg_data[BPP_W-1:0];
                CFG_BIG_ENDIAN: r_cfg.big_endian <= i_cfg_data[0];
                default:        r_cfg            <= r_cfg;
            endcase
        end
    end

    lpw_front u_front (
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_cmd       (i_cmd),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_color     (i_color),
        .i_fifo_full (fifo_full),
        .o_push      (push),
        .o_op        (front_op)
    );

    lpw_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (front_op),
        .o_full  (fifo_full),
        .o_valid (q_valid),
        .o_data  (q_op),
        .i_ready (q_ready)
    );

    lpw_gen u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_op_valid  (q_valid),
        .i_op        (q_op),
        .o_op_ready  (q_ready),
        .o_pix_valid (pix_valid),
        .o_pix       (pix),
        .i_pix_ready (pix_ready)
    );

    lpw_pixel u_pixel (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_pix_valid    (pix_valid),
        .i_pix          (pix),
        .o_pix_ready    (pix_ready),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_byte_address (o_byte_address),
        .o_pixel_bytes  (o_pixel_bytes),
        .o_last_pixel   (o_last_pixel),
        .o_idle         (o_idle)
    );

endmodule

// File: sv/lpw_front.sv
// Front end: accepts commands and precomputes line setup for start commands.
module lpw_front (
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_cmd,
    input  logic signed [15:0]            i_start_x,
    input  logic signed [15:0]            i_start_y,
    input  logic signed [15:0]            i_end_x,
    input  logic signed [15:0]            i_end_y,
    input  logic [23:0]                   i_color,
    input  logic                          i_fifo_full,
    output logic                          o_push,
    output lpw_pkg::t_op                  o_op
);
    import lpw_pkg::*;

    logic [COORD_W:0] dx;
    logic [COORD_W:0] dy;
    logic [COORD_W:0] ndx;
    logic [COORD_W:0] ndy;

    assign o_ready = !i_fifo_full;
    assign o_push  = i_valid && !i_fifo_full;

    always_comb begin
        dx  = {i_end_x[COORD_W-1], i_end_x} - {i_start_x[COORD_W-1], i_start_x};
        dy  = {i_end_y[COORD_W-1], i_end_y} - {i_start_y[COORD_W-1], i_start_y};
        ndx = -dx;
        ndy = -dy;

        o_op.is_start = (i_cmd == CMD_START);
        o_op.start_x  = i_start_x;
        o_op.start_y  = i_start_y;
        o_op.span_x   = dx[COORD_W] ? ndx[COORD_W-1:0] : dx[COORD_W-1:0];
        o_op.span_y   = dy[COORD_W] ? ndy[COORD_W-1:0] : dy[COORD_W-1:0];
        // decreasing unless strictly positive
        o_op.dir_x    = dx[COORD_W] || (dx == '0);
        o_op.dir_y    = dy[COORD_W] || (dy == '0);
        o_op.color    = i_color;
    end

endmodule

// File: sv/lpw_fifo.sv
// Short command queue between the front end and the line generator.
module lpw_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpw_pkg::t_op  i_data,
    output logic          o_full,
    output logic          o_valid,
    output lpw_pkg::t_op  o_data,
    input  logic          i_ready
);
    import lpw_pkg::*;

    t_op               r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              pop;

    assign o_full  = (r_count == CNT_W'(FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_mem[r_wr_ptr] <= i_data;
                r_wr_ptr        <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(FIFO_DEPTH))
        else $error("queue count exceeds depth");

endmodule

// File: sv/lpw_gen.sv
// Bresenham generator: loads line setup and advances one pixel per step command.
module lpw_gen (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_op_valid,
    input  lpw_pkg::t_op  i_op,
    output logic          o_op_ready,
    output logic          o_pix_valid,
    output lpw_pkg::t_pix o_pix,
    input  logic          i_pix_ready
);
    import lpw_pkg::*;

    logic [COORD_W-1:0] r_x;
    logic [COORD_W-1:0] r_y;
    logic [ERR_W-1:0]   r_err;
    logic [COORD_W-1:0] r_major;
    logic [COORD_W-1:0] r_minor;
    logic [COORD_W-1:0] r_steps;
    logic               r_dir_x;
    logic               r_dir_y;
    logic               r_x_major;
    logic [COLOR_W-1:0] r_color;
    logic               r_active;
    logic               r_pix_valid;
    t_pix               r_pix;

    logic               out_free;
    logic               take;
    logic [ERR_W:0]     sum;
    logic               hit;
    logic [ERR_W:0]     n_err;
    logic [COORD_W-1:0] n_x;
    logic [COORD_W-1:0] n_y;
    logic               last;
    logic               ld_x_major;

    assign out_free    = !r_pix_valid || i_pix_ready;
    assign o_op_ready  = i_op.is_start || out_free;
    assign take        = i_op_valid && o_op_ready;
    assign o_pix_valid = r_pix_valid;
    assign o_pix       = r_pix;

    always_comb begin
        sum      = {1'b0, r_err} + (ERR_W + 1)'(r_minor);
        hit      = sum >= (ERR_W + 1)'(r_major);
        n_err    = hit ? sum - (ERR_W + 1)'(r_major) : sum;
        n_x      = r_x;
        n_y      = r_y;
        if (r_x_major || hit) begin
            n_x = r_dir_x ? r_x - 1'b1 : r_x + 1'b1;
        end
        if (!r_x_major || hit) begin
            n_y = r_dir_y ? r_y - 1'b1 : r_y + 1'b1;
        end
        last       = (r_steps <= 16'd1);
        // ties go to the y-major path
        ld_x_major = i_op.span_x > i_op.span_y;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_pix_valid <= 1'b0;
        end else begin
            if (take && !i_op.is_start) begin
                r_pix_valid <= 1'b1;
            end else if (i_pix_ready) begin
                r_pix_valid <= 1'b0;
            end
            if (take) begin
                if (i_op.is_start) begin
                    r_x       <= i_op.start_x;
                    r_y       <= i_op.start_y;
                    r_dir_x   <= i_op.dir_x;
                    r_dir_y   <= i_op.dir_y;
                    r_color   <= i_op.color;
                    r_x_major <= ld_x_major;
                    if (ld_x_major) begin
                        r_major <= i_op.span_x;
                        r_minor <= i_op.span_y;
                        r_err   <= ERR_W'(i_op.span_x >> 1);
                        r_steps <= i_op.span_x;
                        r_active <= (i_op.span_x != '0);
                    end else begin
                        r_major <= i_op.span_y;
                        r_minor <= i_op.span_x;
                        r_err   <= ERR_W'(i_op.span_y >> 1);
                        r_steps <= i_op.span_y;
                        r_active <= (i_op.span_y != '0);
                    end
                end else begin
                    if (r_active) begin
                        r_x          <= n_x;
                        r_y          <= n_y;
                        r_err        <= n_err[ERR_W-1:0];
                        r_steps      <= r_steps - 1'b1;
                        r_active     <= !last;
                        r_pix.idle   <= 1'b0;
                        r_pix.last   <= last;
                        r_pix.x      <= n_x;
                        r_pix.y      <= n_y;
                        r_pix.color  <= r_color;
                    end else begin
                        r_pix.idle   <= 1'b1;
                        r_pix.last   <= 1'b0;
                        r_pix.x      <= '0;
                        r_pix.y      <= '0;
                        r_pix.color  <= '0;
                    end
                end
            end
        end
    end

    a_err_below_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_err < ERR_W'(r_major)))
        else $error("error accumulator reached major span");

    a_minor_le_major: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_minor <= r_major))
        else $error("minor span exceeds major span");

    a_last_ends_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (take && !i_op.is_start && r_active && last) |=> !r_active)
        else $error("line still active after its last pixel");

endmodule

// File: sv/lpw_pixel.sv
// Pixel back end: offset and clip, address products, then the output register.
module lpw_pixel (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lpw_pkg::t_cfg                i_cfg,
    input  logic                         i_pix_valid,
    input  lpw_pkg::t_pix                i_pix,
    output logic                         o_pix_ready,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_write_enable,
    output logic [lpw_pkg::ADDR_W-1:0]   o_byte_address,
    output logic [lpw_pkg::COLOR_W-1:0]  o_pixel_bytes,
    output logic                         o_last_pixel,
    output logic                         o_idle
);
    import lpw_pkg::*;

    // clip stage
    logic                         r_b_valid;
    logic [CLIP_W-1:0]            r_b_px;
    logic [CLIP_W-1:0]            r_b_py;
    logic                         r_b_we;
    logic                         r_b_last;
    logic                         r_b_idle;
    logic [COLOR_W-1:0]           r_b_bytes;
    // product stage
    logic                         r_c_valid;
    logic [CLIP_W+STRIDE_W-1:0]   r_c_prod_y;
    logic [CLIP_W+BPP_W-1:0]      r_c_prod_x;
    logic                         r_c_we;
    logic                         r_c_last;
    logic                         r_c_idle;
    logic [COLOR_W-1:0]           r_c_bytes;
    // output register
    logic                         r_d_valid;

    logic                         d_ready;
    logic                         c_ready;
    logic                         b_ready;
    logic [COORD_W:0]             px;
    logic [COORD_W:0]             py;
    logic                         in_frame;
    logic [COLOR_W-1:0]           bytes;
    logic [ADDR_W-1:0]            addr;

    assign d_ready     = !r_d_valid || i_ready;
    assign c_ready     = !r_c_valid || d_ready;
    assign b_ready     = !r_b_valid || c_ready;
    assign o_pix_ready = b_ready;
    assign o_valid     = r_d_valid;

    always_comb begin
        px = {i_pix.x[COORD_W-1], i_pix.x} + {i_cfg.offset_x[COORD_W-1], i_cfg.offset_x};
        py = {i_pix.y[COORD_W-1], i_pix.y} + {i_cfg.offset_y[COORD_W-1], i_cfg.offset_y};
        in_frame = !px[COORD_W] && (px[COORD_W-1:0] < COORD_W'(FRAME_WIDTH))
                && !py[COORD_W] && (py[COORD_W-1:0] < COORD_W'(FRAME_HEIGHT));
        bytes = i_cfg.big_endian
              ? {i_pix.color[7:0], i_pix.color[15:8], i_pix.color[23:16]}
              : i_pix.color;
        addr  = ADDR_W'(r_c_prod_y) + ADDR_W'(r_c_prod_x);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            if (b_ready) begin
                r_b_valid <= i_pix_valid;
                if (i_pix_valid) begin
                    r_b_px    <= px[CLIP_W-1:0];
                    r_b_py    <= py[CLIP_W-1:0];
                    r_b_we    <= !i_pix.idle && in_frame;
                    r_b_last  <= i_pix.last;
                    r_b_idle  <= i_pix.idle;
                    r_b_bytes <= bytes;
                end
            end
            if (c_ready) begin
                r_c_valid <= r_b_valid;
                if (r_b_valid) begin
                    r_c_prod_y <= r_b_py * i_cfg.stride;
                    r_c_prod_x <= r_b_px * i_cfg.bpp;
                    r_c_we     <= r_b_we;
                    r_c_last   <= r_b_last;
                    r_c_idle   <= r_b_idle;
                    r_c_bytes  <= r_b_bytes;
                end
            end
            if (d_ready) begin
                r_d_valid <= r_c_valid;
                if (r_c_valid) begin
                    o_write_enable <= r_c_we;
                    o_byte_address <= r_c_we ? addr : '0;
                    o_pixel_bytes  <= r_c_we ? r_c_bytes : '0;
                    o_last_pixel   <= r_c_last;
                    o_idle         <= r_c_idle;
                end
            end
        end
    end

    a_idle_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_idle) |-> (!o_write_enable && !o_last_pixel))
        else $error("idle result carries a write or line end");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for line_pixel_writer: command and result traffic against a line tracer.
module testbench;
    import lpw_pkg::*;

    localparam int CYCLE_LIMIT   = 500000;
    // settle wait after the last result, so queue, generator and back end are all empty again
    localparam int SETTLE_CYCLES = 16;
    localparam int PHASE_ITEMS   = 190;

    typedef struct packed {
        logic        we;
        logic [23:0] addr;
        logic [23:0] bytes;
        logic        last;
        logic        idle;
    } t_pixel_write;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_cmd = 1'b0;
    logic signed [15:0]    i_start_x = '0;
    logic signed [15:0]    i_start_y = '0;
    logic signed [15:0]    i_end_x = '0;
    logic signed [15:0]    i_end_y = '0;
    logic [23:0]           i_color = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b0;
    logic                  o_write_enable;
    logic [23:0]           o_byte_address;
    logic [23:0]           o_pixel_bytes;
    logic                  o_last_pixel;
    logic                  o_idle;

    // mirrored configuration
    logic signed [15:0] cfg_ox;
    logic signed [15:0] cfg_oy;
    logic [14:0]        cfg_stride;
    logic [2:0]         cfg_bpp;
    logic               cfg_be;

    // mirrored line generator state
    logic [15:0] ln_x;
    logic [15:0] ln_y;
    logic [16:0] ln_err;
    logic [15:0] ln_major;
    logic [15:0] ln_minor;
    logic [15:0] ln_left;
    logic        ln_dir_x;
    logic        ln_dir_y;
    logic        ln_x_major;
    logic [23:0] ln_color;
    logic        ln_active;

    t_pixel_write pending_writes[$];
    t_pixel_write want_w;
    int           fail_count = 0;
    int           cycle_count = 0;
    int           stall_left = 0;
    int           stall_pick;
    bit           gaps_on = 1'b1;
    bit           stalls_on = 1'b1;

    line_pixel_writer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_start_x      (i_start_x),
        .i_start_y      (i_start_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_color        (i_color),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_write_enable (o_write_enable),
        .o_byte_address (o_byte_address),
        .o_pixel_bytes  (o_pixel_bytes),
        .o_last_pixel   (o_last_pixel),
        .o_idle         (o_idle)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d results still pending", $time, pending_writes.size());
            $display("line_pixel_writer verification failed");
            $finish;
        end
    end

    function automatic int sx16(logic [15:0] v);
        return int'(signed'(v));
    endfunction

    function automatic logic [15:0] step16(logic [15:0] pos, logic down);
        return down ? pos - 16'd1 : pos + 16'd1;
    endfunction

    function automatic void reset_tracer();
        cfg_ox     = '0;
        cfg_oy     = '0;
        cfg_stride = STRIDE_RESET;
        cfg_bpp    = BPP_RESET;
        cfg_be     = 1'b0;
        ln_x = '0; ln_y = '0; ln_err = '0; ln_major = '0; ln_minor = '0; ln_left = '0;
        ln_dir_x = 1'b0; ln_dir_y = 1'b0; ln_x_major = 1'b0; ln_color = '0; ln_active = 1'b0;
    endfunction

    function automatic void apply_register(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
        case (idx)
            CFG_OFFSET_X:   cfg_ox = data;
            CFG_OFFSET_Y:   cfg_oy = data;
            CFG_STRIDE:     cfg_stride = data[14:0];
            CFG_BPP:        cfg_bpp = data[2:0];
            CFG_BIG_ENDIAN: cfg_be = data[0];
            default: ;
        endcase
    endfunction

    // Advance the line tracer by one accepted command; a step queues one pixel write.
    function automatic void trace_command(logic cmd, logic [15:0] sx, logic [15:0] sy,
                                          logic [15:0] ex, logic [15:0] ey, logic [23:0] col);
        int dx, dy, adx, ady, err, px, py;
        logic [31:0] addr;
        logic last;
        t_pixel_write w;
        if (cmd == CMD_START) begin
            dx = sx16(ex) - sx16(sx);
            dy = sx16(ey) - sx16(sy);
            ln_dir_x = (dx > 0) ? 1'b0 : 1'b1;
            ln_dir_y = (dy > 0) ? 1'b0 : 1'b1;
            adx = (dx < 0) ? -dx : dx;
            ady = (dy < 0) ? -dy : dy;
            ln_x = sx;
            ln_y = sy;
            ln_color = col;
            ln_x_major = adx > ady;
            ln_major = ln_x_major ? 16'(adx) : 16'(ady);
            ln_minor = ln_x_major ? 16'(ady) : 16'(adx);
            ln_err = {1'b0, ln_major} >> 1;
            ln_left = ln_major;
            ln_active = ln_major != 0;
            return;
        end
        w = '0;
        if (!ln_active) begin
            w.idle = 1'b1;
            pending_writes.push_back(w);
            return;
        end
        err = int'(ln_err) + int'(ln_minor);
        if (ln_x_major) begin
            ln_x = step16(ln_x, ln_dir_x);
            if (err >= int'(ln_major)) begin
                err -= int'(ln_major);
                ln_y = step16(ln_y, ln_dir_y);
            end
        end else begin
            ln_y = step16(ln_y, ln_dir_y);
            if (err >= int'(ln_major)) begin
                err -= int'(ln_major);
                ln_x = step16(ln_x, ln_dir_x);
            end
        end
        ln_err = 17'(err);
        last = ln_left <= 16'd1;
        ln_left = ln_left - 16'd1;
        if (last)
            ln_active = 1'b0;
        px = sx16(ln_x) + sx16(cfg_ox);
        py = sx16(ln_y) + sx16(cfg_oy);
        if (px >= 0 && px < FRAME_WIDTH && py >= 0 && py < FRAME_HEIGHT) begin
            w.we = 1'b1;
            addr = 32'(py) * 32'(cfg_stride) + 32'(px) * 32'(cfg_bpp);
            w.addr = addr[23:0];
            w.bytes = cfg_be ? {ln_color[7:0], ln_color[15:8], ln_color[23:16]} : ln_color;
        end
        w.last = last;
        pending_writes.push_back(w);
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_writes.size() == 0) begin
                $display("%0t: unexpected result: expected none actual we=%0b addr=%0h",
                         $time, o_write_enable, o_byte_address);
                fail_count++;
            end else begin
                want_w = pending_writes.pop_front();
                check_field("write_enable", want_w.we, o_write_enable);
                check_field("byte_address", want_w.addr, o_byte_address);
                check_field("pixel_bytes", want_w.bytes, o_pixel_bytes);
                check_field("last_pixel", want_w.last, o_last_pixel);
                check_field("idle", want_w.idle, o_idle);
            end
        end
    end

    // result side back-pressure: mostly short stalls, a few long ones
    always @(negedge i_clk) begin
        if (!stalls_on) begin
            i_ready = 1'b1;
        end else if (stall_left > 0) begin
            i_ready = 1'b0;
            stall_left--;
        end else begin
            stall_pick = $urandom_range(0, 99);
            if (stall_pick < 75) begin
                i_ready = 1'b1;
            end else begin
                i_ready = 1'b0;
                stall_left = (stall_pick < 97) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // all tasks below start and end at a falling edge
    task automatic send_cmd(input logic cmd, input logic [15:0] sx, input logic [15:0] sy,
                            input logic [15:0] ex, input logic [15:0] ey,
                            input logic [23:0] col);
        int gap;
        gap = pick_gap();
        repeat (gap) @(negedge i_clk);
        i_cmd     = cmd;
        i_start_x = sx;
        i_start_y = sy;
        i_end_x   = ex;
        i_end_y   = ey;
        i_color   = col;
        i_valid   = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        trace_command(cmd, sx, sy, ex, ey, col);
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic send_step();
        send_cmd(CMD_STEP, 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 24'($urandom()));
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_index = idx;
        i_cfg_data  = data;
        i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic wait_for_drain();
        while (pending_writes.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // bits above each register's width carry junk that must be dropped
    task automatic apply_settings(input logic [15:0] ox, input logic [15:0] oy,
                                  input logic [14:0] stride, input logic [2:0] bpp,
                                  input logic be);
        wait_for_drain();
        write_reg(CFG_OFFSET_X, ox);
        write_reg(CFG_OFFSET_Y, oy);
        write_reg(CFG_STRIDE, {1'($urandom()), stride});
        write_reg(CFG_BPP, {13'($urandom()), bpp});
        write_reg(CFG_BIG_ENDIAN, {15'($urandom()), be});
    endtask

    task automatic test_idle_steps();
        send_step();
        send_step();
    endtask

    task automatic test_short_lines();
        // diagonal: tie goes to the y-major path; extra step finds no line
        send_cmd(CMD_START, 16'sd0, 16'sd0, 16'sd3, 16'sd3, 24'h123456);
        repeat (4) send_step();
        // zero length draws nothing
        send_cmd(CMD_START, 16'sd10, 16'sd10, 16'sd10, 16'sd10, 24'hFFFFFF);
        send_step();
        // crosses the right frame edge
        send_cmd(CMD_START, 16'sd1022, 16'sd5, 16'sd1026, 16'sd3, 24'hA5C3E7);
        repeat (4) send_step();
        // y-major, walks off the left edge
        send_cmd(CMD_START, 16'sd1, 16'sd1, -16'sd1, 16'sd4, 24'h000000);
        repeat (3) send_step();
    endtask

    task automatic test_extreme_endpoints();
        send_cmd(CMD_START, -16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 24'hFFFFFF);
        repeat (2) send_step();
        // restart abandons the long line
        send_cmd(CMD_START, 16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 24'h000000);
        send_step();
        send_cmd(CMD_START, 16'sd1023, 16'sd1023, 16'sd1023, 16'sd1021, 24'h00FF00);
        repeat (2) send_step();
    endtask

    task automatic test_unused_index();
        wait_for_drain();
        for (int i = CFG_BIG_ENDIAN + 1; i < 2 ** CFG_IDX_W; i++)
            write_reg(CFG_IDX_W'(i), 16'($urandom()));
        send_cmd(CMD_START, 16'sd100, 16'sd200, 16'sd104, 16'sd201, 24'h89ABCD);
        repeat (4) send_step();
    endtask

    task automatic run_random_lines(input int count);
        int sent, r, len, dmin, dx, dy, tx, ty, ox, oy, steps;
        sent = 0;
        while (sent < count) begin
            ox = sx16(cfg_ox);
            oy = sx16(cfg_oy);
            r = $urandom_range(0, 99);
            if (r < 8) begin
                send_cmd(1'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                         16'($urandom()), 24'($urandom()));
                sent++;
            end else begin
                r = $urandom_range(0, 99);
                len = (r < 8) ? 0 : (r < 85) ? $urandom_range(1, 24) : $urandom_range(25, 160);
                dmin = ($urandom_range(0, 9) == 0) ? len : $urandom_range(0, len);
                if ($urandom_range(0, 1)) begin
                    dx = len;
                    dy = dmin;
                end else begin
                    dx = dmin;
                    dy = len;
                end
                if ($urandom_range(0, 1))
                    dx = -dx;
                if ($urandom_range(0, 1))
                    dy = -dy;
                // aim near the visible frame after the offset is applied
                tx = $urandom_range(0, FRAME_WIDTH + 15) - 8;
                ty = $urandom_range(0, FRAME_HEIGHT + 15) - 8;
                r = $urandom_range(0, 99);
                steps = (r < 70) ? len : (r < 85) ? $urandom_range(0, len)
                                                  : len + $urandom_range(1, 3);
                send_cmd(CMD_START, 16'(tx - ox), 16'(ty - oy), 16'(tx + dx - ox),
                         16'(ty + dy - oy), 24'($urandom()));
                repeat (steps) send_step();
                sent += 1 + steps;
            end
            if ($urandom_range(0, 199) == 0) begin
                wait_for_drain();
                repeat ($urandom_range(20, 60)) @(negedge i_clk);
            end
        end
    endtask

    task automatic run_phase(input logic [15:0] ox, input logic [15:0] oy,
                             input logic [14:0] stride, input logic [2:0] bpp,
                             input logic be, input bit gaps, input bit stalls);
        apply_settings(ox, oy, stride, bpp, be);
        gaps_on = gaps;
        stalls_on = stalls;
        run_random_lines(PHASE_ITEMS);
    endtask

    task automatic test_random_phases();
        run_phase(16'h0000, 16'h0000, 15'd1024, 3'd3, 1'b1, 1'b0, 1'b0);
        run_phase(16'($urandom_range(0, 400) - 200), 16'($urandom_range(0, 400) - 200),
                  15'd0, 3'd0, 1'b0, 1'b1, 1'b1);
        run_phase(16'h7FFF, 16'h7FFF, 15'h7FFF, 3'd7, 1'b1, 1'b1, 1'b1);
        run_phase(16'h8000, 16'h8000, 15'd16384, 3'd1, 1'b0, 1'b1, 1'b0);
        run_phase(16'($urandom()), 16'($urandom()), 15'($urandom()), 3'($urandom()),
                  1'($urandom()), 1'b1, 1'b1);
        run_phase(-16'sd5, 16'sd1000, 15'd3000, 3'd5, 1'b1, 1'b0, 1'b1);
        run_phase(16'sd1023, -16'sd1023, 15'd2048, 3'd2, 1'b0, 1'b1, 1'b1);
        run_phase(16'($urandom_range(0, 64) - 32), 16'($urandom_range(0, 64) - 32),
                  15'h7FFF, 3'd6, 1'b1, 1'b1, 1'b1);
        run_phase(16'h0000, 16'h0000, STRIDE_RESET, BPP_RESET, 1'b0, 1'b1, 1'b1);
    endtask

    initial begin
        reset_tracer();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        test_idle_steps();
        test_short_lines();
        test_extreme_endpoints();
        test_unused_index();
        test_random_phases();
        wait_for_drain();
        if (fail_count == 0)
            $display("line_pixel_writer verification clean");
        else
            $display("line_pixel_writer verification failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/lpw_pkg.sv
sv/lpw_front.sv
sv/lpw_fifo.sv
sv/lpw_gen.sv
sv/lpw_pixel.sv
sv/line_pixel_writer.sv
tb/testbench.sv
